// File: hw/rtl/smbp_pkg.sv
`default_nettype none

package smbp_pkg;

  // result kinds
  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_DATA    = 3'd1;
  localparam logic [2:0] KIND_SBYTE   = 3'd2;
  localparam logic [2:0] KIND_SEND    = 3'd3;
  localparam logic [2:0] KIND_STEND   = 3'd4;
  localparam logic [2:0] KIND_TEND    = 3'd5;
  localparam logic [2:0] KIND_TRUNC   = 3'd6;

  // configuration register indexes
  localparam logic CFG_WANTED_TYPE = 1'b0;
  localparam logic CFG_END_TYPE    = 1'b1;

  localparam logic [7:0] WANTED_TYPE_RESET = 8'd0;
  localparam logic [7:0] END_TYPE_RESET    = 8'd127;

  // depth of the queue between parser and output stage
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  byte_value;
    logic [7:0]  offset;
    logic [15:0] handle;
    logic [7:0]  length;
    logic [7:0]  string_number;
    logic        last_of_run;
  } result_t;

  // all results caused by one input byte
  typedef struct packed {
    result_t res0;
    result_t res1;
    logic    two;
  } run_t;

  function automatic result_t make_result(
    input logic [2:0]  kind,
    input logic [7:0]  bv,
    input logic [7:0]  off,
    input logic [15:0] hdl,
    input logic [7:0]  len,
    input logic [7:0]  num
  );
    result_t r;
    r.kind          = kind;
    r.byte_value    = bv;
    r.offset        = off;
    r.handle        = hdl;
    r.length        = len;
    r.string_number = num;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/smbp_front.sv
`default_nettype none

module smbp_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [7:0]       cfg_data,
  input  wire logic             in_accept,
  input  wire logic [7:0]       table_byte,
  input  wire logic             final_byte,
  output logic                  push,
  output smbp_pkg::run_t        push_run
);

  typedef enum logic [2:0] {
    PH_TYPE, PH_LEN, PH_HLO, PH_HHI, PH_FORM, PH_STR, PH_DONE
  } phase_t;

  logic [7:0]  wanted_type;
  logic [7:0]  end_type;

  phase_t      phase, phase_next;
  logic [7:0]  position, position_next;
  logic [7:0]  cur_len, cur_len_next;
  logic [15:0] cur_handle, cur_handle_next;
  logic        matched, matched_next;
  logic        prev_zero, prev_zero_next;
  logic        str_open, str_open_next;
  logic [7:0]  str_count, str_count_next;

  logic        a_valid;
  smbp_pkg::result_t a_res;
  logic        e_valid;
  smbp_pkg::result_t e_res;
  logic        table_over;
  logic        at_boundary;
  logic [7:0]  pos_inc;
  logic [7:0]  eff_len;
  logic [15:0] hdl_full;

  // hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_type <= smbp_pkg::WANTED_TYPE_RESET;
      end_type    <= smbp_pkg::END_TYPE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        smbp_pkg::CFG_WANTED_TYPE: wanted_type <= cfg_data;
        smbp_pkg::CFG_END_TYPE:    end_type    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pos_inc  = position + 8'd1;
  assign eff_len  = (cur_len < 8'd4) ? 8'd4 : cur_len;
  assign hdl_full = {table_byte, cur_handle[7:0]};

  // classify one byte and work out its results
  always_comb begin
    phase_next      = phase;
    position_next   = position;
    cur_len_next    = cur_len;
    cur_handle_next = cur_handle;
    matched_next    = matched;
    prev_zero_next  = prev_zero;
    str_open_next   = str_open;
    str_count_next  = str_count;
    a_valid         = 1'b0;
    a_res           = '0;
    e_valid         = 1'b0;
    e_res           = '0;
    table_over      = 1'b0;
    at_boundary     = 1'b0;

    case (phase)
      PH_DONE: ;
      PH_TYPE: begin
        if (table_byte == end_type) begin
          a_valid    = 1'b1;
          a_res      = smbp_pkg::make_result(smbp_pkg::KIND_TEND, '0, '0, '0, '0, '0);
          table_over = 1'b1;
        end else begin
          matched_next    = (table_byte == wanted_type);
          cur_len_next    = '0;
          cur_handle_next = '0;
          position_next   = '0;
          prev_zero_next  = 1'b0;
          str_open_next   = 1'b0;
          str_count_next  = '0;
          phase_next      = PH_LEN;
        end
      end
      PH_LEN: begin
        cur_len_next = table_byte;
        if (table_byte <= 8'd4) matched_next = 1'b0;
        phase_next = PH_HLO;
      end
      PH_HLO: begin
        cur_handle_next = {cur_handle[15:8], table_byte};
        phase_next      = PH_HHI;
      end
      PH_HHI: begin
        cur_handle_next = hdl_full;
        if (matched) begin
          a_valid = 1'b1;
          a_res   = smbp_pkg::make_result(smbp_pkg::KIND_HEADER, '0, '0, hdl_full,
                                          cur_len, '0);
        end
        position_next  = 8'd4;
        prev_zero_next = 1'b0;
        str_open_next  = 1'b0;
        phase_next     = (eff_len > 8'd4) ? PH_FORM : PH_STR;
      end
      PH_FORM: begin
        if (matched) begin
          a_valid = 1'b1;
          a_res   = smbp_pkg::make_result(smbp_pkg::KIND_DATA, table_byte, position,
                                          cur_handle, cur_len, '0);
        end
        position_next = pos_inc;
        if (pos_inc >= eff_len) phase_next = PH_STR;
      end
      PH_STR: begin
        if (table_byte != 8'd0) begin
          if (!str_open) begin
            str_open_next = 1'b1;
            if (str_count != 8'hff) str_count_next = str_count + 8'd1;
          end
          if (matched) begin
            a_valid = 1'b1;
            a_res   = smbp_pkg::make_result(smbp_pkg::KIND_SBYTE, table_byte, '0,
                                            cur_handle, cur_len, str_count_next);
          end
          prev_zero_next = 1'b0;
        end else if (prev_zero) begin
          if (matched) begin
            a_valid = 1'b1;
            a_res   = smbp_pkg::make_result(smbp_pkg::KIND_STEND, '0, '0,
                                            cur_handle, cur_len, str_count);
          end
          phase_next  = PH_TYPE;
          at_boundary = 1'b1;
        end else begin
          if (str_open && matched) begin
            a_valid = 1'b1;
            a_res   = smbp_pkg::make_result(smbp_pkg::KIND_SEND, '0, '0,
                                            cur_handle, cur_len, str_count);
          end
          str_open_next  = 1'b0;
          prev_zero_next = 1'b1;
        end
      end
      default: ;
    endcase

    // close the table or mark truncation on the final byte
    if (table_over) begin
      if (!final_byte) phase_next = PH_DONE;
    end else if (final_byte && phase != PH_DONE) begin
      e_valid = 1'b1;
      e_res   = smbp_pkg::make_result(at_boundary ? smbp_pkg::KIND_TEND
                                                  : smbp_pkg::KIND_TRUNC,
                                      '0, '0, '0, '0, '0);
    end

    if (final_byte) begin
      phase_next      = PH_TYPE;
      position_next   = '0;
      cur_len_next    = '0;
      cur_handle_next = '0;
      matched_next    = 1'b0;
      prev_zero_next  = 1'b0;
      str_open_next   = 1'b0;
      str_count_next  = '0;
    end
  end

  // pack results of this byte into one queue entry
  always_comb begin
    push_run = '0;
    if (a_valid) begin
      push_run.res0 = a_res;
      if (e_valid) begin
        push_run.res1             = e_res;
        push_run.res1.last_of_run = 1'b1;
        push_run.two              = 1'b1;
      end else begin
        push_run.res0.last_of_run = 1'b1;
      end
    end else begin
      push_run.res0             = e_res;
      push_run.res0.last_of_run = 1'b1;
    end
  end

  assign push = in_accept && (a_valid || e_valid);

  // advance parser state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TYPE;
      position   <= '0;
      cur_len    <= '0;
      cur_handle <= '0;
      matched    <= 1'b0;
      prev_zero  <= 1'b0;
      str_open   <= 1'b0;
      str_count  <= '0;
    end else if (in_accept) begin
      phase      <= phase_next;
      position   <= position_next;
      cur_len    <= cur_len_next;
      cur_handle <= cur_handle_next;
      matched    <= matched_next;
      prev_zero  <= prev_zero_next;
      str_open   <= str_open_next;
      str_count  <= str_count_next;
    end
  end

  // a skipped table tail never produces a request
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && phase == PH_DONE) |-> !push)
    else $error("request pushed while skipping table tail");

  // a matched structure never carries a short length past the header
  assert property (@(posedge clk) disable iff (rst)
    (matched && (phase == PH_FORM || phase == PH_STR)) |-> (cur_len > 8'd4))
    else $error("matched structure with short length");

  // the final byte always leaves the parser waiting for a type byte
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && final_byte) |=> (phase == PH_TYPE && !matched))
    else $error("final byte did not clear parser");

endmodule

`default_nettype wire

// File: hw/rtl/smbp_queue.sv
`default_nettype none

module smbp_queue #(
  parameter int Depth = smbp_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire smbp_pkg::run_t push_run,
  input  wire logic           pop,
  output smbp_pkg::run_t      head,
  output logic                empty,
  output logic                full
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  smbp_pkg::run_t  mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == DepthCnt);
  assign head  = mem[rd_ptr];

  // store incoming runs
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_run;
  end

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      if (pop)  rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      if (push && !pop)      count <= count + CntW'(1);
      else if (pop && !push) count <= count - CntW'(1);
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");

  assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("pop from empty queue");

  assert property (@(posedge clk) disable iff (rst) count <= DepthCnt)
    else $error("queue occupancy out of range");

endmodule

`default_nettype wire

// File: hw/rtl/smbp_back.sv
`default_nettype none

module smbp_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire smbp_pkg::run_t head,
  input  wire logic           empty,
  output logic                pop,
  input  wire logic           out_stall,
  output logic                out_valid,
  output smbp_pkg::result_t   out_res
);

  logic              pend;
  smbp_pkg::result_t pend_res;
  logic              load;

  assign load = !out_valid || !out_stall;
  assign pop  = load && !pend && !empty;

  // advance output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (load) begin
      if (pend) begin
        out_valid <= 1'b1;
        pend      <= 1'b0;
      end else if (!empty) begin
        out_valid <= 1'b1;
        pend      <= head.two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // hold the request payload and the second result of a run
  always_ff @(posedge clk) begin
    if (load) begin
      if (pend) begin
        out_res <= pend_res;
      end else if (!empty) begin
        out_res  <= head.res0;
        pend_res <= head.res1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) pend |-> out_valid)
    else $error("pending result without a shown request");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !out_res.last_of_run) |=> (out_valid && pend == 1'b0))
    else $error("second result of a run lost");

  // a stalled request stays shown and unchanged
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_res)))
    else $error("stalled request changed");

endmodule

`default_nettype wire

// File: hw/rtl/smbios_structure_stream_parser.sv
// SMBIOS structure table parser, one table byte per request.
// Input channel: in_valid/in_stall with table_byte and final_byte. A byte is
// taken at a rising edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall with kind, byte_value, offset, handle,
// length, string_number and last_of_run; one result per accepted edge.
// Each byte gives zero, one or two results; last_of_run marks the last one.
// The parser classifies a byte in the cycle it is taken and queues its
// results; each result passes through the queue and an output register.
// Throughput is one byte per cycle while in_stall is low; a byte that gives
// two results shows them in turn; a queue of QueueDepth entries holds them.
// in_stall rises only when that queue is full, so a stalled receiver
// backs up into the input after QueueDepth runs plus the output register.
// Configuration: cfg_we with cfg_index (0 wanted type, 1 end type) and
// cfg_data, written while the block is idle.
// Reset (rst, synchronous) empties the queue, drops any shown result, clears
// the parser and sets wanted type 0, end type 127.
`default_nettype none

module smbios_structure_stream_parser #(
  parameter int QueueDepth = smbp_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  table_byte,
  input  wire logic        final_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       kind,
  output logic [7:0]       byte_value,
  output logic [7:0]       offset,
  output logic [15:0]      handle,
  output logic [7:0]       length,
  output logic [7:0]       string_number,
  output logic             last_of_run
);

  logic              in_accept;
  logic              push;
  smbp_pkg::run_t    push_run;
  logic              pop;
  smbp_pkg::run_t    head;
  logic              empty;
  logic              full;
  smbp_pkg::result_t out_res;

  assign in_stall  = full;
  assign in_accept = in_valid && !full;

  smbp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_accept  (in_accept),
    .table_byte (table_byte),
    .final_byte (final_byte),
    .push       (push),
    .push_run   (push_run)
  );

  smbp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_run (push_run),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  smbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign kind          = out_res.kind;
  assign byte_value    = out_res.byte_value;
  assign offset        = out_res.offset;
  assign handle        = out_res.handle;
  assign length        = out_res.length;
  assign string_number = out_res.string_number;
  assign last_of_run   = out_res.last_of_run;

endmodule

`default_nettype wire

// File: tb/smbios_structure_stream_parser_test.sv
module smbios_structure_stream_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 8;

  typedef enum logic [2:0] {
    PS_TYPE,
    PS_LENGTH,
    PS_HANDLE_LO,
    PS_HANDLE_HI,
    PS_FORMATTED,
    PS_STRINGS,
    PS_SKIP
  } parse_state_t;

  // Tracks the parse of the table and holds the results still owed by the block
  class stream_book;
    smbp_pkg::result_t owed_q[$];
    smbp_pkg::result_t run_q[$];
    logic [7:0]   wanted;
    logic [7:0]   stop_type;
    parse_state_t st;
    logic [7:0]   pos;
    logic [7:0]   len_byte;
    logic [15:0]  hdl;
    bit           match_on;
    bit           last_zero;
    bit           in_string;
    logic [7:0]   str_count;
    int           errors;

    function new();
      wanted    = smbp_pkg::WANTED_TYPE_RESET;
      stop_type = smbp_pkg::END_TYPE_RESET;
      errors    = 0;
      clear();
    endfunction

    function void clear();
      st        = PS_TYPE;
      pos       = 8'd0;
      len_byte  = 8'd0;
      hdl       = 16'd0;
      match_on  = 1'b0;
      last_zero = 1'b0;
      in_string = 1'b0;
      str_count = 8'd0;
    endfunction

    function void set_reg(logic idx, logic [7:0] v);
      if (idx == smbp_pkg::CFG_WANTED_TYPE) wanted = v;
      else stop_type = v;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void add(logic [2:0] k, logic [7:0] bv, logic [7:0] off, logic [15:0] h,
                      logic [7:0] l, logic [7:0] num);
      smbp_pkg::result_t r;
      r.kind          = k;
      r.byte_value    = bv;
      r.offset        = off;
      r.handle        = h;
      r.length        = l;
      r.string_number = num;
      r.last_of_run   = 1'b0;
      run_q.push_back(r);
    endfunction

    // Advance the parse by one accepted request and queue what it owes
    function void take_byte(logic [7:0] b, logic fin);
      bit         boundary;
      bit         over;
      logic [7:0] eff;
      smbp_pkg::result_t r;
      boundary = 1'b0;
      over     = 1'b0;
      run_q.delete();
      if (st == PS_SKIP) begin
        if (fin) clear();
        return;
      end
      eff = (len_byte < 8'd4) ? 8'd4 : len_byte;
      case (st)
        PS_TYPE: begin
          if (b == stop_type) begin
            add(smbp_pkg::KIND_TEND, 8'd0, 8'd0, 16'd0, 8'd0, 8'd0);
            over = 1'b1;
          end else begin
            match_on  = (b == wanted);
            len_byte  = 8'd0;
            hdl       = 16'd0;
            pos       = 8'd0;
            last_zero = 1'b0;
            in_string = 1'b0;
            str_count = 8'd0;
            st        = PS_LENGTH;
          end
        end
        PS_LENGTH: begin
          len_byte = b;
          if (b <= 8'd4) match_on = 1'b0;
          st = PS_HANDLE_LO;
        end
        PS_HANDLE_LO: begin
          hdl[7:0] = b;
          st = PS_HANDLE_HI;
        end
        PS_HANDLE_HI: begin
          hdl[15:8] = b;
          if (match_on) add(smbp_pkg::KIND_HEADER, 8'd0, 8'd0, hdl, len_byte, 8'd0);
          pos       = 8'd4;
          last_zero = 1'b0;
          in_string = 1'b0;
          st        = (eff > 8'd4) ? PS_FORMATTED : PS_STRINGS;
        end
        PS_FORMATTED: begin
          if (match_on) add(smbp_pkg::KIND_DATA, b, pos, hdl, len_byte, 8'd0);
          pos = pos + 8'd1;
          if (pos >= eff) st = PS_STRINGS;
        end
        default: begin
          if (b != 8'd0) begin
            if (!in_string) begin
              in_string = 1'b1;
              if (str_count != 8'd255) str_count = str_count + 8'd1;
            end
            if (match_on) add(smbp_pkg::KIND_SBYTE, b, 8'd0, hdl, len_byte, str_count);
            last_zero = 1'b0;
          end else if (last_zero) begin
            if (match_on) add(smbp_pkg::KIND_STEND, 8'd0, 8'd0, hdl, len_byte, str_count);
            st       = PS_TYPE;
            boundary = 1'b1;
          end else begin
            // an empty string takes no number and gives no end mark
            if (in_string && match_on)
              add(smbp_pkg::KIND_SEND, 8'd0, 8'd0, hdl, len_byte, str_count);
            in_string = 1'b0;
            last_zero = 1'b1;
          end
        end
      endcase
      if (over) begin
        if (fin) clear();
        else st = PS_SKIP;
      end else if (fin) begin
        if (boundary) add(smbp_pkg::KIND_TEND, 8'd0, 8'd0, 16'd0, 8'd0, 8'd0);
        else add(smbp_pkg::KIND_TRUNC, 8'd0, 8'd0, 16'd0, 8'd0, 8'd0);
        clear();
      end
      for (int i = 0; i < run_q.size(); i++) begin
        r = run_q[i];
        r.last_of_run = (i == run_q.size() - 1);
        owed_q.push_back(r);
      end
    endfunction

    function void field_check(string name, int unsigned want, int unsigned got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // Compare a delivered result with the oldest one owed
    function void check(smbp_pkg::result_t got);
      smbp_pkg::result_t want;
      if (owed_q.size() == 0) begin
        $error("result with nothing owed: kind %0d", got.kind);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      field_check("kind", 32'(want.kind), 32'(got.kind));
      field_check("byte_value", 32'(want.byte_value), 32'(got.byte_value));
      field_check("offset", 32'(want.offset), 32'(got.offset));
      field_check("handle", 32'(want.handle), 32'(got.handle));
      field_check("length", 32'(want.length), 32'(got.length));
      field_check("string_number", 32'(want.string_number), 32'(got.string_number));
      field_check("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  table_byte;
  logic        final_byte;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  kind;
  logic [7:0]  byte_value;
  logic [7:0]  offset;
  logic [15:0] handle;
  logic [7:0]  length;
  logic [7:0]  string_number;
  logic        last_of_run;

  stream_book  book;
  logic [7:0]  tbl[$];
  bit          no_gaps;
  int          phase_bytes;
  int          idle_cycles;
  smbp_pkg::result_t seen;

  smbios_structure_stream_parser u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .table_byte    (table_byte),
    .final_byte    (final_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .byte_value    (byte_value),
    .offset        (offset),
    .handle        (handle),
    .length        (length),
    .string_number (string_number),
    .last_of_run   (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stall: short bursts, a few long ones, and quiet stretches
  initial begin
    int n;
    int r;
    out_stall = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        out_stall <= 1'b0;
        n = $urandom_range(30, 80);
      end else if (r < 55) begin
        out_stall <= 1'b0;
        n = $urandom_range(1, 4);
      end else if (r < 93) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 3);
      end else begin
        out_stall <= 1'b1;
        n = $urandom_range(10, 40);
      end
      repeat (n) @(posedge clk);
    end
  end

  // Note accepted requests, check delivered results, and watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) book.take_byte(table_byte, final_byte);
      if (out_valid && !out_stall) begin
        seen.kind          = kind;
        seen.byte_value    = byte_value;
        seen.offset        = offset;
        seen.handle        = handle;
        seen.length        = length;
        seen.string_number = string_number;
        seen.last_of_run   = last_of_run;
        book.check(seen);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("smbios_structure_stream_parser verification failed");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    table_byte <= b;
    final_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    phase_bytes++;
  endtask

  // Send the built table, flagging its last byte as final
  task automatic send_table();
    for (int i = 0; i < tbl.size(); i++) send_byte(tbl[i], i == tbl.size() - 1);
  endtask

  // Drop in_valid, let the last accepted request be noted, then wait until nothing is owed
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    book.set_reg(idx, v);
  endtask

  function automatic logic [7:0] pick_type();
    logic [7:0] t;
    if ($urandom_range(0, 9) < 6) return book.wanted;
    do t = 8'($urandom); while (t == book.stop_type);
    return t;
  endfunction

  function automatic logic [7:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'($urandom_range(5, 16));
    if (r < 85) return 8'($urandom_range(0, 4));
    if (r < 95) return 8'($urandom_range(17, 64));
    return 8'($urandom_range(200, 255));
  endfunction

  // Append one structure: header, formatted area, strings and double zero
  task automatic add_structure(input logic [7:0] t, input logic [7:0] len, input int nstr,
                               input bit lead_empty);
    logic [15:0] h;
    int          slen;
    h = 16'($urandom);
    tbl.push_back(t);
    tbl.push_back(len);
    tbl.push_back(h[7:0]);
    tbl.push_back(h[15:8]);
    for (int i = 4; i < len; i++) tbl.push_back(8'($urandom));
    if (nstr == 0) begin
      tbl.push_back(8'h00);
    end else begin
      if (lead_empty) tbl.push_back(8'h00);
      for (int i = 0; i < nstr; i++) begin
        slen = $urandom_range(1, 6);
        repeat (slen) tbl.push_back(8'($urandom_range(1, 255)));
        tbl.push_back(8'h00);
      end
    end
    tbl.push_back(8'h00);
  endtask

  // One random table, mostly well formed, sometimes plain noise
  task automatic random_table();
    int n;
    int mode;
    int cut;
    tbl.delete();
    no_gaps = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 6) == 0) begin
      n = $urandom_range(1, 30);
      for (int i = 0; i < n; i++)
        send_byte(8'($urandom), (i == n - 1) || ($urandom_range(0, 9) == 0));
    end else begin
      n = $urandom_range(1, 4);
      repeat (n)
        add_structure(pick_type(), pick_length(), $urandom_range(0, 4),
                      $urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 99);
      if (mode < 40) begin
        // end marker, then ignored trailing bytes
        tbl.push_back(book.stop_type);
        repeat ($urandom_range(0, 4)) tbl.push_back(8'($urandom));
      end else if (mode >= 75) begin
        // cut the table short
        cut = $urandom_range(0, tbl.size() - 2);
        while (tbl.size() > cut + 1) void'(tbl.pop_back());
      end
      send_table();
    end
    if ($urandom_range(0, 9) == 0) drain();
  endtask

  task automatic random_phase(input int budget);
    phase_bytes = 0;
    while (phase_bytes < budget) random_table();
  endtask

  initial begin
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = smbp_pkg::CFG_WANTED_TYPE;
    cfg_data    = 8'd0;
    in_valid    = 1'b0;
    table_byte  = 8'd0;
    final_byte  = 1'b0;
    no_gaps     = 1'b0;
    idle_cycles = 0;
    book        = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // matched structure with an empty leading string, short structure, end marker
    tbl = '{8'h00, 8'h06, 8'h34, 8'h12, 8'hAA, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00,
            8'h00, 8'h02, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h7F, 8'h01};
    send_table();
    // final byte in the middle of a header
    tbl = '{8'hFF, 8'h05};
    send_table();
    // final byte closing a structure
    tbl = '{8'h00, 8'h05, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00};
    send_table();
    // end marker that is itself final
    tbl = '{8'h7F};
    send_table();
    drain();
    random_phase(20);

    settle();
    write_reg(smbp_pkg::CFG_WANTED_TYPE, 8'hFF);
    write_reg(smbp_pkg::CFG_END_TYPE, 8'h00);
    // string count runs past its ceiling
    tbl.delete();
    tbl = '{8'hFF, 8'h06, 8'hCD, 8'hAB, 8'h11, 8'h22};
    repeat (260) begin
      tbl.push_back(8'($urandom_range(1, 255)));
      tbl.push_back(8'h00);
    end
    tbl.push_back(8'h00);
    send_table();
    random_phase(20);

    settle();
    write_reg(smbp_pkg::CFG_WANTED_TYPE, 8'h00);
    write_reg(smbp_pkg::CFG_END_TYPE, 8'hFF);
    random_phase(20);

    settle();
    write_reg(smbp_pkg::CFG_WANTED_TYPE, 8'($urandom_range(1, 127)));
    write_reg(smbp_pkg::CFG_END_TYPE, 8'($urandom_range(128, 254)));
    random_phase(20);

    drain();
    repeat (16) @(posedge clk);
    if (book.pending() != 0) begin
      $error("results still owed: %0d", book.pending());
      book.errors++;
    end
    if (book.errors == 0) begin
      $display("smbios_structure_stream_parser verification clean");
    end else begin
      $display("smbios_structure_stream_parser verification failed");
    end
    $finish;
  end

endmodule
